/* rtl/core/text_console_glyph_renderer_top_macros.svh */
// Assertion macros for the text console glyph renderer.
// Used by text_console_glyph_renderer_top; expects a clock named clock and a reset named reset.
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_TOP_MACROS_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_TOP_MACROS_SVH

// same-cycle implication
`define TCGR_ASSERT_IMPL(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("tcgr assertion failed");

// next-cycle implication
`define TCGR_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("tcgr assertion failed");

`endif

/* rtl/core/tcgr_pkg.sv */
// Shared types and constants for the text console glyph renderer.
// No dependencies; used by text_console_glyph_renderer_top.
package tcgr_pkg;

   localparam int MAX_GLYPH_ROWS = 16;
   localparam int GLYPH_COUNT    = 256;
   localparam int STORE_DEPTH    = GLYPH_COUNT * MAX_GLYPH_ROWS;
   localparam int ADDR_W         = $clog2(STORE_DEPTH);
   localparam int ROW_CNT_W      = $clog2(MAX_GLYPH_ROWS + 1);

   localparam logic [23:0] INK_COLOR    = 24'hC0C0C0;
   localparam logic [7:0]  NEWLINE_CODE = 8'd10;
   localparam logic [11:0] CURSOR_MAX   = 12'd4095;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_PRINT = 1'b1;

   // register indexes (word address)
   localparam logic [1:0] REG_SCREEN_WIDTH = 2'd0;
   localparam logic [1:0] REG_PITCH_WORDS  = 2'd1;
   localparam logic [1:0] REG_GLYPH_WIDTH  = 2'd2;
   localparam logic [1:0] REG_GLYPH_HEIGHT = 2'd3;

   localparam logic [12:0] SCREEN_WIDTH_RST = 13'd1024;
   localparam logic [12:0] PITCH_WORDS_RST  = 13'd1024;
   localparam logic [3:0]  GLYPH_WIDTH_RST  = 4'd8;
   localparam logic [4:0]  GLYPH_HEIGHT_RST = 5'd16;

   typedef struct packed {
      logic       func;
      logic [7:0] char_code;
      logic [3:0] glyph_row;
      logic [7:0] glyph_bits;
   } req_item_type;

   typedef struct packed {
      logic [23:0] pixel_offset;
      logic [7:0]  pixel_mask;
      logic [23:0] pixel_color;
      logic        last_row;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_MUL_Y,
      ST_MUL_OFF,
      ST_ROW,
      ST_WRAP
   } state_type;

endpackage

/* rtl/core/text_console_glyph_renderer_top.sv */
// Text console glyph renderer: font store, cursor, row sequencer, register port.
// Depends on tcgr_pkg and text_console_glyph_renderer_top_macros.svh.
//
//   channel   dir   handshake                 payload
//   req       in    req_valid / req_stall     tcgr_pkg::req_item_type
//   rsp       out   rsp_valid / rsp_stall     tcgr_pkg::rsp_item_type
//   csr       in    psel/penable/pwrite       paddr[3:2] register, pwdata/prdata 32 bits
//
// A load or a newline is done in the accept step; a printed glyph steps through accept,
//   three multiply-add passes (column, line, row-0 offset), one step per row, paced by
//   the font store read, and one wrap check, with rows = min(glyph_height, 16).
// Reset restores the cursor and registers; the font store is not cleared.
// A stalled rsp holds the row loop; req is stalled while a transaction is in work.
`include "text_console_glyph_renderer_top_macros.svh"

module text_console_glyph_renderer_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tcgr_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tcgr_pkg::rsp_item_type rsp_item,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [3:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   // ---------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------
   tcgr_pkg::state_type state_ff, state_in;

   logic [12:0] sw_ff, sw_in;
   logic [12:0] pitch_ff, pitch_in;
   logic [3:0]  gw_ff, gw_in;
   logic [4:0]  gh_ff, gh_in;

   logic [11:0] col_ff, col_in;
   logic [11:0] line_ff, line_in;
   logic [7:0]  code_ff, code_in;
   logic [23:0] x0_ff, x0_in;
   logic [23:0] off_ff, off_in;     // holds y0 after the line pass
   logic [tcgr_pkg::ROW_CNT_W-1:0] rows_ff, rows_in;
   logic [tcgr_pkg::ROW_CNT_W-1:0] row_ff, row_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   tcgr_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   // font store, registered read
   logic [7:0] font_mem [tcgr_pkg::STORE_DEPTH];
   logic [7:0] font_data_ff;
   logic [tcgr_pkg::ADDR_W-1:0] rd_addr, wr_addr;
   logic       wr_en;

   // shared multiply-add unit: res = (a * b + c) mod 2^24
   logic [23:0] unit_a, unit_c, unit_res;
   logic [12:0] unit_b;
   logic [36:0] unit_prod;

   logic        req_take, slot_free, last_row, cfg_wr;
   logic [12:0] next_col;
   logic [7:0]  mask_rev, col_mask;

   assign unit_prod = unit_a * unit_b;
   assign unit_res  = unit_prod[23:0] + unit_c;

   assign req_stall = (state_ff != tcgr_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign last_row  = (row_ff == rows_ff - tcgr_pkg::ROW_CNT_W'(1));
   assign next_col  = {1'b0, col_ff} + 13'd1;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // ---------------------------------------------------------------------
   // Register port
   // ---------------------------------------------------------------------
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;

   always_comb begin
      sw_in    = sw_ff;
      pitch_in = pitch_ff;
      gw_in    = gw_ff;
      gh_in    = gh_ff;
      if (cfg_wr) begin
         case (paddr[3:2])
            tcgr_pkg::REG_SCREEN_WIDTH: sw_in    = pwdata[12:0];
            tcgr_pkg::REG_PITCH_WORDS:  pitch_in = pwdata[12:0];
            tcgr_pkg::REG_GLYPH_WIDTH:  gw_in    = pwdata[3:0];
            tcgr_pkg::REG_GLYPH_HEIGHT: gh_in    = pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         tcgr_pkg::REG_SCREEN_WIDTH: prdata = {19'd0, sw_ff};
         tcgr_pkg::REG_PITCH_WORDS:  prdata = {19'd0, pitch_ff};
         tcgr_pkg::REG_GLYPH_WIDTH:  prdata = {28'd0, gw_ff};
         tcgr_pkg::REG_GLYPH_HEIGHT: prdata = {27'd0, gh_ff};
         default:                    prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Row mask: font MSB is column 0, clipped to glyph width
   // ---------------------------------------------------------------------
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         mask_rev[i] = font_data_ff[7-i];
      end
      if (gw_ff >= 4'd8) begin
         col_mask = 8'hFF;
      end else begin
         col_mask = 8'((9'd1 << gw_ff) - 9'd1);
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      line_in      = line_ff;
      code_in      = code_ff;
      x0_in        = x0_ff;
      off_in       = off_ff;
      rows_in      = rows_ff;
      row_in       = row_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      unit_a       = 24'd0;
      unit_b       = 13'd0;
      unit_c       = 24'd0;
      wr_en        = 1'b0;

      case (state_ff)
         tcgr_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_item.func == tcgr_pkg::FUNC_LOAD) begin
                  wr_en = (32'(req_item.char_code) < tcgr_pkg::GLYPH_COUNT) &&
                          (32'(req_item.glyph_row) < tcgr_pkg::MAX_GLYPH_ROWS);
               end else if (req_item.char_code == tcgr_pkg::NEWLINE_CODE) begin
                  col_in = 12'd0;
                  if (line_ff != tcgr_pkg::CURSOR_MAX) begin
                     line_in = line_ff + 12'd1;
                  end
               end else begin
                  code_in = req_item.char_code;
                  row_in  = '0;
                  if (32'(gh_ff) > tcgr_pkg::MAX_GLYPH_ROWS) begin
                     rows_in = tcgr_pkg::ROW_CNT_W'(tcgr_pkg::MAX_GLYPH_ROWS);
                  end else begin
                     rows_in = tcgr_pkg::ROW_CNT_W'(gh_ff);
                  end
                  state_in = tcgr_pkg::ST_MUL_X;
               end
            end
         end

         tcgr_pkg::ST_MUL_X: begin
            unit_a   = 24'(col_ff);
            unit_b   = 13'(gw_ff);
            unit_c   = 24'd1;
            x0_in    = unit_res;
            state_in = tcgr_pkg::ST_MUL_Y;
         end

         tcgr_pkg::ST_MUL_Y: begin
            unit_a   = 24'(line_ff);
            unit_b   = 13'(gh_ff);
            unit_c   = 24'd1;
            off_in   = unit_res;
            state_in = tcgr_pkg::ST_MUL_OFF;
         end

         tcgr_pkg::ST_MUL_OFF: begin
            unit_a = off_ff;
            unit_b = pitch_ff;
            unit_c = x0_ff;
            off_in = unit_res;
            if (rows_ff == '0) begin
               state_in = tcgr_pkg::ST_WRAP;
            end else begin
               state_in = tcgr_pkg::ST_ROW;
            end
         end

         tcgr_pkg::ST_ROW: begin
            // next row start is one pitch further on
            unit_a = 24'(pitch_ff);
            unit_b = 13'd1;
            unit_c = off_ff;
            if (slot_free) begin
               rsp_valid_in             = 1'b1;
               rsp_item_in.pixel_offset = off_ff;
               rsp_item_in.pixel_mask   = mask_rev & col_mask;
               rsp_item_in.pixel_color  = tcgr_pkg::INK_COLOR;
               rsp_item_in.last_row     = last_row;
               off_in                   = unit_res;
               if (last_row) begin
                  row_in   = '0;
                  state_in = tcgr_pkg::ST_WRAP;
               end else begin
                  row_in = row_ff + tcgr_pkg::ROW_CNT_W'(1);
               end
            end
         end

         tcgr_pkg::ST_WRAP: begin
            unit_a = 24'(next_col);
            unit_b = 13'(gw_ff) + 13'd1;
            unit_c = 24'd0;
            if (next_col[12] || (unit_res >= 24'(sw_ff))) begin
               col_in = 12'd0;
               if (line_ff != tcgr_pkg::CURSOR_MAX) begin
                  line_in = line_ff + 12'd1;
               end
            end else begin
               col_in = next_col[11:0];
            end
            state_in = tcgr_pkg::ST_IDLE;
         end

         default: begin
            state_in = tcgr_pkg::ST_IDLE;
         end
      endcase
   end

   // font addresses; read follows the next row so data lines up with row_ff
   always_comb begin
      int rd_base;
      int wr_base;
      rd_base = 0;
      if (32'(code_in) < tcgr_pkg::GLYPH_COUNT) begin
         rd_base = 32'(code_in) * tcgr_pkg::MAX_GLYPH_ROWS;
      end
      wr_base = 32'(req_item.char_code) * tcgr_pkg::MAX_GLYPH_ROWS;
      rd_addr = tcgr_pkg::ADDR_W'(rd_base + 32'(row_in));
      wr_addr = tcgr_pkg::ADDR_W'(wr_base + 32'(req_item.glyph_row));
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         font_mem[wr_addr] <= req_item.glyph_bits;
      end
      font_data_ff <= font_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcgr_pkg::ST_IDLE;
         sw_ff        <= tcgr_pkg::SCREEN_WIDTH_RST;
         pitch_ff     <= tcgr_pkg::PITCH_WORDS_RST;
         gw_ff        <= tcgr_pkg::GLYPH_WIDTH_RST;
         gh_ff        <= tcgr_pkg::GLYPH_HEIGHT_RST;
         col_ff       <= 12'd0;
         line_ff      <= 12'd0;
         rows_ff      <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sw_ff        <= sw_in;
         pitch_ff     <= pitch_in;
         gw_ff        <= gw_in;
         gh_ff        <= gh_in;
         col_ff       <= col_in;
         line_ff      <= line_in;
         rows_ff      <= rows_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      x0_ff       <= x0_in;
      off_ff      <= off_in;
      rsp_item_ff <= rsp_item_in;
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `TCGR_ASSERT_NEXT(a_glyph_starts_seq,
      req_take && req_item.func == tcgr_pkg::FUNC_PRINT &&
      req_item.char_code != tcgr_pkg::NEWLINE_CODE,
      state_ff == tcgr_pkg::ST_MUL_X)
   `TCGR_ASSERT_IMPL(a_row_in_range, state_ff == tcgr_pkg::ST_ROW, row_ff < rows_ff)
   `TCGR_ASSERT_IMPL(a_mask_clipped, rsp_valid && gw_ff < 4'd8,
      (rsp_item.pixel_mask & ~col_mask) == 8'd0)
   `TCGR_ASSERT_NEXT(a_line_monotonic, 1'b1, line_ff >= $past(line_ff))

endmodule

/* tb/tb.sv */
// Self-checking testbench for text_console_glyph_renderer_top.
// Needs tcgr_pkg and the renderer RTL. Predicts every glyph-row transaction
// from its own font and cursor model and checks rsp traffic field by field.
module tb;

   // ------------------------------------------------------------------
   // Clock, reset and DUT pins. Every DUT input starts at a known value.
   // ------------------------------------------------------------------
   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   tcgr_pkg::req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall;
   tcgr_pkg::rsp_item_type rsp_item;
   logic         psel = 1'b0;
   logic         penable = 1'b0;
   logic         pwrite = 1'b0;
   logic [3:0]   paddr = '0;
   logic [31:0]  pwdata = '0;
   logic [31:0]  prdata;
   logic         pready;

   text_console_glyph_renderer_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial forever #10 clock = ~clock;

   // ------------------------------------------------------------------
   // Console mirror: register shadows, font image and cursor.
   // The register shadows are also what the stimulus side consults to
   // decide which font rows a print will read.
   // ------------------------------------------------------------------
   logic [12:0] cfg_screen_width = tcgr_pkg::SCREEN_WIDTH_RST;
   logic [12:0] cfg_pitch_words  = tcgr_pkg::PITCH_WORDS_RST;
   logic [3:0]  cfg_glyph_width  = tcgr_pkg::GLYPH_WIDTH_RST;
   logic [4:0]  cfg_glyph_height = tcgr_pkg::GLYPH_HEIGHT_RST;

   logic [7:0]  font_mirror [tcgr_pkg::STORE_DEPTH];
   logic [11:0] cur_col  = '0;
   logic [11:0] cur_line = '0;

   tcgr_pkg::rsp_item_type expected_rows [$];

   // Which font entries the stimulus has already written; a print is only
   // issued once all rows it will read are present.
   bit          font_loaded [tcgr_pkg::STORE_DEPTH];

   typedef struct {
      tcgr_pkg::req_item_type item;
      int unsigned            gap;
   } feed_entry_type;
   feed_entry_type feed_queue [$];

   int           error_count  = 0;
   int           rows_checked = 0;
   int           tx_calm_left = 0;

   function automatic void next_text_line();
      cur_col = '0;
      if (cur_line < tcgr_pkg::CURSOR_MAX) cur_line = cur_line + 12'd1;
   endfunction

   // Apply one accepted transaction to the mirror; queue the glyph rows it draws.
   function automatic void advance_console(input tcgr_pkg::req_item_type it);
      int unsigned  rows, cols, nc, base;
      logic [7:0]   colmask, fb, mask;
      logic [63:0]  x0, y0, off;
      tcgr_pkg::rsp_item_type row_out;
      if (it.func == tcgr_pkg::FUNC_LOAD) begin
         font_mirror[int'(it.char_code) * tcgr_pkg::MAX_GLYPH_ROWS + int'(it.glyph_row)] =
            it.glyph_bits;
         return;
      end
      if (it.char_code == tcgr_pkg::NEWLINE_CODE) begin
         next_text_line();
         return;
      end
      rows    = (cfg_glyph_height > tcgr_pkg::MAX_GLYPH_ROWS) ? tcgr_pkg::MAX_GLYPH_ROWS
                                                               : cfg_glyph_height;
      cols    = (cfg_glyph_width > 8) ? 8 : cfg_glyph_width;
      colmask = (cols >= 8) ? 8'hFF : 8'((1 << cols) - 1);
      x0      = 64'(cur_col) * 64'(cfg_glyph_width) + 64'd1;
      y0      = 64'(cur_line) * 64'(cfg_glyph_height) + 64'd1;
      base    = int'(it.char_code) * tcgr_pkg::MAX_GLYPH_ROWS;
      for (int unsigned r = 0; r < rows; r++) begin
         fb = font_mirror[base + r];
         // font bit 7 is the leftmost pixel, mask bit 0 is column 0
         for (int i = 0; i < 8; i++) mask[i] = fb[7 - i];
         off = (y0 + 64'(r)) * 64'(cfg_pitch_words) + x0;
         row_out.pixel_offset = off[23:0];
         row_out.pixel_mask   = mask & colmask;
         row_out.pixel_color  = tcgr_pkg::INK_COLOR;
         row_out.last_row     = (r + 1 == rows);
         expected_rows.push_back(row_out);
      end
      nc = int'(cur_col) + 1;
      if (nc > tcgr_pkg::CURSOR_MAX ||
          64'(nc) * (64'(cfg_glyph_width) + 64'd1) >= 64'(cfg_screen_width))
         next_text_line();
      else
         cur_col = nc[11:0];
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers: build transactions and queue them for the driver.
   // ------------------------------------------------------------------
   function automatic void queue_item(input tcgr_pkg::req_item_type it);
      feed_entry_type e;
      // occasional runs of back-to-back offers
      if (tx_calm_left == 0 && $urandom_range(0, 15) == 0) tx_calm_left = 24;
      if (tx_calm_left != 0) begin
         tx_calm_left--;
         e.gap = 0;
      end else begin
         e.gap = $urandom_range(0, 17);
      end
      e.item = it;
      feed_queue.push_back(e);
   endfunction

   function automatic void load_row(input logic [7:0] code, input logic [3:0] row,
                                    input logic [7:0] bits);
      tcgr_pkg::req_item_type it;
      it.func       = tcgr_pkg::FUNC_LOAD;
      it.char_code  = code;
      it.glyph_row  = row;
      it.glyph_bits = bits;
      font_loaded[int'(code) * tcgr_pkg::MAX_GLYPH_ROWS + int'(row)] = 1'b1;
      queue_item(it);
   endfunction

   // Print a character; any glyph row it would read that is still blank gets
   // loaded first, so a print never touches an unwritten font entry.
   function automatic void print_char(input logic [7:0] code);
      tcgr_pkg::req_item_type it;
      int unsigned  needed;
      needed = (cfg_glyph_height > tcgr_pkg::MAX_GLYPH_ROWS) ? tcgr_pkg::MAX_GLYPH_ROWS
                                                              : cfg_glyph_height;
      if (code != tcgr_pkg::NEWLINE_CODE) begin
         for (int unsigned r = 0; r < needed; r++)
            if (!font_loaded[int'(code) * tcgr_pkg::MAX_GLYPH_ROWS + r])
               load_row(code, 4'(r), 8'($urandom));
      end
      it.func       = tcgr_pkg::FUNC_PRINT;
      it.char_code  = code;
      it.glyph_row  = 4'($urandom);     // don't-care on a print
      it.glyph_bits = 8'($urandom);
      queue_item(it);
   endfunction

   function automatic logic [7:0] any_printable();
      logic [7:0] code;
      do code = 8'($urandom); while (code == tcgr_pkg::NEWLINE_CODE);
      return code;
   endfunction

   // Mostly text with a small working set of glyphs, plus font rewrites,
   // newlines and the odd fresh glyph.
   function automatic void random_traffic(input int n);
      logic [7:0] hot_glyphs [6] = '{8'h00, 8'h20, 8'h41, 8'h7F, 8'h80, 8'hFF};
      int         pick;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 15)
            load_row(hot_glyphs[$urandom_range(0, 5)], 4'($urandom), 8'($urandom));
         else if (pick < 25)
            load_row(8'($urandom), 4'($urandom), 8'($urandom));
         else if (pick < 37)
            print_char(tcgr_pkg::NEWLINE_CODE);
         else if (pick < 98)
            print_char(hot_glyphs[$urandom_range(0, 5)]);
         else
            print_char(any_printable());
      end
   endfunction

   // ------------------------------------------------------------------
   // Register port: setup cycle, then access until pready.
   // ------------------------------------------------------------------
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         tcgr_pkg::REG_SCREEN_WIDTH: cfg_screen_width = value[12:0];
         tcgr_pkg::REG_PITCH_WORDS:  cfg_pitch_words  = value[12:0];
         tcgr_pkg::REG_GLYPH_WIDTH:  cfg_glyph_width  = value[3:0];
         tcgr_pkg::REG_GLYPH_HEIGHT: cfg_glyph_height = value[4:0];
         default: ;
      endcase
   endtask

   task automatic set_layout(input int sw, input int pw, input int gw, input int gh);
      csr_write(tcgr_pkg::REG_SCREEN_WIDTH, 32'(sw));
      csr_write(tcgr_pkg::REG_PITCH_WORDS, 32'(pw));
      csr_write(tcgr_pkg::REG_GLYPH_WIDTH, 32'(gw));
      csr_write(tcgr_pkg::REG_GLYPH_HEIGHT, 32'(gh));
   endtask

   // Waits until nothing is queued or offered and every row has come back,
   // then waits on so that a print with no rows and the last wrap check finish.
   task automatic wait_drained();
      while (feed_queue.size() != 0 || req_valid || expected_rows.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Driver: offers queued transactions, holds payload while stalled and
   // idles for the gap drawn with each transaction.
   // ------------------------------------------------------------------
   int unsigned  tx_gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         tx_gap_left <= 0;
      end else begin
         if (req_valid && !req_stall) advance_console(req_item);
         if (!req_valid || !req_stall) begin
            if (tx_gap_left != 0) begin
               tx_gap_left <= tx_gap_left - 1;
               req_valid   <= 1'b0;
            end else if (feed_queue.size() != 0) begin
               feed_entry_type e;
               e = feed_queue.pop_front();
               req_item    <= e.item;
               req_valid   <= 1'b1;
               tx_gap_left <= e.gap;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: checks each accepted row against the oldest prediction and
   // draws a hold-off after it. Calm stretches give back-to-back accepts.
   // ------------------------------------------------------------------
   int unsigned rx_hold    = 0;
   int unsigned choke_left = 0;
   bit          choke_done = 1'b0;
   bit          rx_calm    = 1'b0;

   assign rsp_stall = (rx_hold != 0) || (choke_left != 0);

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rx_hold <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (expected_rows.size() == 0) begin
            $display("%0t: unexpected glyph row, actual offset 0x%0h mask 0x%0h",
                     $time, rsp_item.pixel_offset, rsp_item.pixel_mask);
            error_count++;
         end else begin
            tcgr_pkg::rsp_item_type want;
            want = expected_rows.pop_front();
            check_field("pixel_offset", want.pixel_offset, rsp_item.pixel_offset);
            check_field("pixel_mask", want.pixel_mask, rsp_item.pixel_mask);
            check_field("pixel_color", want.pixel_color, rsp_item.pixel_color);
            check_field("last_row", want.last_row, rsp_item.last_row);
         end
         rows_checked <= rows_checked + 1;
         if (rows_checked % 32 == 31) rx_calm <= $urandom_range(0, 1);
         rx_hold <= rx_calm ? 0 : $urandom_range(0, 17);
      end else if (rx_hold != 0) begin
         rx_hold <= rx_hold - 1;
      end
   end

   // One long receiver choke while the sender still has work queued, so the
   // row loop backs up and req gets stalled.
   always @(posedge clock) begin
      if (reset) begin
         choke_left <= 0;
      end else if (!choke_done && rows_checked >= 20 && feed_queue.size() > 5) begin
         choke_left <= 400;
         choke_done <= 1'b1;
      end else if (choke_left != 0) begin
         choke_left <= choke_left - 1;
      end
   end

   // ------------------------------------------------------------------
   // Test sequence. Each later phase reprograms the layout while idle.
   // ------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset layout: one glyph with edge patterns, printed around a newline.
      load_row(8'hFF, 4'd0, 8'h00);
      load_row(8'hFF, 4'd1, 8'hFF);
      load_row(8'hFF, 4'd2, 8'h80);
      load_row(8'hFF, 4'd3, 8'h01);
      load_row(8'hFF, 4'd4, 8'hAA);
      load_row(8'hFF, 4'd5, 8'h55);
      for (int r = 6; r < 16; r++) load_row(8'hFF, 4'(r), 8'($urandom));
      print_char(8'hFF);
      print_char(tcgr_pkg::NEWLINE_CODE);
      print_char(8'hFF);
      print_char(8'h00);
      random_traffic(15);
      wait_drained();

      // Largest layout.
      set_layout(4096, 4096, 8, 16);
      random_traffic(15);
      wait_drained();

      // Smallest layout: every glyph wraps the line.
      set_layout(1, 1, 1, 1);
      random_traffic(15);
      wait_drained();

      repeat (3) begin
         set_layout($urandom_range(1, 4096), $urandom_range(1, 4096),
                    $urandom_range(1, 8), $urandom_range(1, 16));
         random_traffic(10);
         wait_drained();
      end

      // Wide and tall glyphs: mask limited to 8 columns, rows capped at 16,
      // positions still use the programmed sizes.
      set_layout(300, 77, 12, 20);
      print_char(8'hFF);
      random_traffic(8);
      wait_drained();

      // Zero-width glyph: rows drawn with an empty mask.
      set_layout(600, 50, 0, 3);
      print_char(8'hFF);
      random_traffic(6);
      wait_drained();

      // Zero-size glyphs draw nothing but still move the cursor.
      set_layout(4096, 1, 0, 0);
      repeat (6) print_char(any_printable());
      wait_drained();

      // A few lines further down at the largest layout, then more text.
      set_layout(4096, 4096, 8, 16);
      repeat (8) print_char(tcgr_pkg::NEWLINE_CODE);
      random_traffic(15);
      wait_drained();

      if (error_count == 0 && expected_rows.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
